FILE: hw/rtl/awb_pkg.sv
package awb_pkg;

    // Field and fixed-point widths
    localparam int WATER_W  = 20;
    localparam int FRAC_W   = 16;
    localparam int EXP_Q    = 30;
    localparam int A_W      = 17;
    localparam int B_W      = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // Serial arithmetic unit sizes
    localparam int MUL_W    = 40;
    localparam int MUL_PW   = 2 * MUL_W;
    localparam int DIV_NW   = 56;
    localparam int DIV_DW   = 40;
    localparam int RAD_W    = 76;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int SER_TERMS = 24;

    // Register reset values
    localparam logic [A_W-1:0]     RST_A = 17'd64225;
    localparam logic [B_W-1:0]     RST_B = 19'd35000;
    localparam logic [A_W-1:0]     RST_C = 17'd19661;
    localparam logic [A_W-1:0]     RST_D = 17'd65536;
    localparam logic [A_W-1:0]     FRAC_ONE = A_W'(1) << FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUNOFF_A,
        CFG_SAT_B,
        CFG_RECHARGE_C,
        CFG_DISCHARGE_D,
        CFG_INIT_SOIL,
        CFG_INIT_GROUND
    } t_cfg_idx;

    typedef struct packed {
        logic [WATER_W-1:0] precipitation;
        logic [WATER_W-1:0] potential_evap;
        logic               series_start;
    } t_in_item;

    typedef struct packed {
        logic [WATER_W-1:0] surface_runoff;
        logic [WATER_W-1:0] groundwater;
        logic [WATER_W-1:0] available_water;
        logic [WATER_W-1:0] et_opportunity;
        logic [WATER_W-1:0] soil_moisture;
        logic [WATER_W-1:0] actual_evap;
    } t_out_item;

endpackage

FILE: hw/rtl/awb_mul.sv
module awb_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [awb_pkg::MUL_W-1:0]  i_a,
    input  logic [awb_pkg::MUL_W-1:0]  i_b,
    output logic                       o_done,
    output logic [awb_pkg::MUL_PW-1:0] o_p
);
    import awb_pkg::*;

    localparam int CNT_W = $clog2(MUL_W + 1);

    logic [MUL_PW-1:0] r_a;
    logic [MUL_PW-1:0] r_acc;
    logic [MUL_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    // Shift-add: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= MUL_PW'(i_a);
                r_b   <= i_b;
                r_acc <= '0;
                r_cnt <= CNT_W'(MUL_W);
            end else if (r_cnt != '0) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a    <= r_a << 1;
                r_b    <= r_b >> 1;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

FILE: hw/rtl/awb_div.sv
module awb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [awb_pkg::DIV_NW-1:0] i_num,
    input  logic [awb_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [awb_pkg::DIV_NW-1:0] o_q
);
    import awb_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_q[DIV_NW-1]};
    assign ge    = (trial >= {1'b0, r_den});

    // Restoring divide: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_NW);
            end else if (r_cnt != '0) begin
                r_rem  <= ge ? DIV_DW'(trial - {1'b0, r_den}) : trial[DIV_DW-1:0];
                r_q    <= {r_q[DIV_NW-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

FILE: hw/rtl/abcd_water_balance_step_top.sv
// When PE/b is 32 or more the exponential series is skipped. Otherwise the 24-term
//   exponential series runs on the shared bit-serial multiplier and divider, followed
//   by up to 31 serial multiplies for the integer part of PE/b.
// One item at a time: the next item is taken once the result is registered.
// Reset (synchronous, active low) loads register defaults and zero state, then runs a
//   pass computing exp(-1) before the first item is accepted.
module abcd_water_balance_step_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  awb_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output awb_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [awb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [awb_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import awb_pkg::*;

    typedef enum logic [4:0] {
        ST_BOOT, ST_IDLE, ST_M1, ST_M2, ST_M3, ST_SQRT, ST_M4, ST_D1, ST_D2,
        ST_SER_M, ST_SER_D, ST_POW, ST_S, ST_G1, ST_G2, ST_Q1, ST_Q2, ST_OUT
    } t_state;

    localparam logic [30:0] Q_ONE = 31'(1) << EXP_Q;

    t_state               r_state;
    logic [A_W-1:0]       r_cfg_a, r_cfg_c, r_cfg_d;
    logic [B_W-1:0]       r_cfg_b;
    logic [WATER_W-1:0]   r_init_soil, r_init_ground;
    logic [WATER_W-1:0]   r_prev_soil, r_prev_ground;
    logic [WATER_W-1:0]   r_pe, r_w, r_y, r_s, r_g, r_qo;
    logic [MUL_PW-1:0]    r_t1;
    logic [RAD_W-1:0]     r_rad;
    logic [ROOT_W+2:0]    r_srem;
    logic [ROOT_W-1:0]    r_root;
    logic [5:0]           r_scnt;
    logic [30:0]          r_f, r_e1;
    logic signed [33:0]   r_sum;
    logic [4:0]           r_k, r_n;
    logic                 r_boot;
    logic [MUL_W-1:0]     r_ma, r_mb;
    logic                 r_ms;
    logic [DIV_NW-1:0]    r_dn;
    logic [DIV_DW-1:0]    r_dd;
    logic                 r_ds;
    logic                 r_ov;
    t_out_item            r_out;

    logic                 mul_done, div_done;
    logic [MUL_PW-1:0]    mul_p;
    logic [DIV_NW-1:0]    div_q;

    awb_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ms),
        .i_a(r_ma), .i_b(r_mb), .o_done(mul_done), .o_p(mul_p)
    );

    awb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ds),
        .i_num(r_dn), .i_den(r_dd), .o_done(div_done), .o_q(div_q)
    );

    // Clamp coefficients into range
    logic [A_W-1:0] a_c, c_c, d_c;
    logic [B_W-1:0] b_c;
    assign a_c = (r_cfg_a == '0) ? A_W'(1) : ((r_cfg_a > FRAC_ONE) ? FRAC_ONE : r_cfg_a);
    assign b_c = (r_cfg_b == '0) ? B_W'(1) : r_cfg_b;
    assign c_c = (r_cfg_c > FRAC_ONE) ? FRAC_ONE : r_cfg_c;
    assign d_c = (r_cfg_d > FRAC_ONE) ? FRAC_ONE : r_cfg_d;

    // Available water for the arriving item
    logic [WATER_W-1:0] soil_sel, w_now, diff_wy;
    logic [WATER_W:0]   w_sum;
    logic [36:0]        s2f_now, s2f_reg;
    assign soil_sel = i_in_item.series_start ? r_init_soil : r_prev_soil;
    assign w_sum    = {1'b0, i_in_item.precipitation} + {1'b0, soil_sel};
    assign w_now    = w_sum[WATER_W] ? '1 : w_sum[WATER_W-1:0];
    assign s2f_now  = {21'({1'b0, w_now} + 21'(b_c)), 16'b0};
    assign s2f_reg  = {21'({1'b0, r_w} + 21'(b_c)), 16'b0};
    assign diff_wy  = r_w - r_y;

    // Square root step: two radicand bits per cycle
    logic [ROOT_W+4:0] sq_trial, sq_cmp;
    logic              sq_ge;
    assign sq_trial = {r_srem, r_rad[RAD_W-1:RAD_W-2]};
    assign sq_cmp   = (ROOT_W+5)'({r_root, 2'b01});
    assign sq_ge    = (sq_trial >= sq_cmp);

    // Series accumulation
    logic signed [33:0] tq, sum_next;
    logic [30:0]        e_clamp, e_pow;
    assign tq       = 34'(div_q[30:0]);
    assign sum_next = r_k[0] ? (r_sum - tq) : (r_sum + tq);
    assign e_clamp  = sum_next[33] ? '0 : sum_next[30:0];
    assign e_pow    = mul_p[EXP_Q+30:EXP_Q];

    // Groundwater and runoff results
    logic [WATER_W-1:0] g_sat, q_sat, y_min;
    logic [38:0]        q_sum;
    assign g_sat = (|div_q[DIV_NW-1:WATER_W]) ? '1 : div_q[WATER_W-1:0];
    assign q_sum = 39'(r_t1[37:0]) + 39'(mul_p[37:0]);
    assign q_sat = (|q_sum[38:36]) ? '1 : q_sum[35:16];
    assign y_min = (div_q > DIV_NW'(r_w)) ? r_w : div_q[WATER_W-1:0];

    // Take register writes only while idle and no item arrives
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_in_valid;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_BOOT;
            r_cfg_a       <= RST_A;
            r_cfg_b       <= RST_B;
            r_cfg_c       <= RST_C;
            r_cfg_d       <= RST_D;
            r_init_soil   <= '0;
            r_init_ground <= '0;
            r_prev_soil   <= '0;
            r_prev_ground <= '0;
            r_ms          <= 1'b0;
            r_ds          <= 1'b0;
            r_ov          <= 1'b0;
            r_boot        <= 1'b1;
        end else begin
            r_ms <= 1'b0;
            r_ds <= 1'b0;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            // Register writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RUNOFF_A:    r_cfg_a       <= i_cfg_data[A_W-1:0];
                    CFG_SAT_B:       r_cfg_b       <= i_cfg_data[B_W-1:0];
                    CFG_RECHARGE_C:  r_cfg_c       <= i_cfg_data[A_W-1:0];
                    CFG_DISCHARGE_D: r_cfg_d       <= i_cfg_data[A_W-1:0];
                    CFG_INIT_SOIL:   r_init_soil   <= i_cfg_data[WATER_W-1:0];
                    CFG_INIT_GROUND: r_init_ground <= i_cfg_data[WATER_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                // Compute exp(-1) once after reset
                ST_BOOT: begin
                    r_boot  <= 1'b1;
                    r_f     <= Q_ONE;
                    r_sum   <= 34'(Q_ONE);
                    r_k     <= 5'd1;
                    r_ma    <= MUL_W'(Q_ONE);
                    r_mb    <= MUL_W'(Q_ONE);
                    r_ms    <= 1'b1;
                    r_state <= ST_SER_M;
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_pe <= i_in_item.potential_evap;
                        r_w  <= w_now;
                        if (i_in_item.series_start) begin
                            r_prev_ground <= r_init_ground;
                        end
                        r_ma    <= MUL_W'(s2f_now);
                        r_mb    <= MUL_W'(s2f_now);
                        r_ms    <= 1'b1;
                        r_state <= ST_M1;
                    end
                end
                ST_M1: begin
                    if (mul_done) begin
                        r_t1    <= mul_p;
                        r_ma    <= MUL_W'(a_c);
                        r_mb    <= MUL_W'(r_w);
                        r_ms    <= 1'b1;
                        r_state <= ST_M2;
                    end
                end
                ST_M2: begin
                    if (mul_done) begin
                        r_ma    <= mul_p[MUL_W-1:0];
                        r_mb    <= MUL_W'(b_c);
                        r_ms    <= 1'b1;
                        r_state <= ST_M3;
                    end
                end
                // Discriminant into the root unit
                ST_M3: begin
                    if (mul_done) begin
                        r_rad   <= r_t1[RAD_W-1:0] - RAD_W'({mul_p[RAD_W-19:0], 18'b0});
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_scnt  <= 6'(ROOT_W);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_srem <= sq_ge ? (ROOT_W+3)'(sq_trial - sq_cmp)
                                    : sq_trial[ROOT_W+2:0];
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                    r_rad  <= r_rad << 2;
                    r_scnt <= r_scnt - 1'b1;
                    if (r_scnt == 6'd1) begin
                        r_ma    <= MUL_W'({r_w, 1'b0});
                        r_mb    <= MUL_W'(b_c);
                        r_ms    <= 1'b1;
                        r_state <= ST_M4;
                    end
                end
                ST_M4: begin
                    if (mul_done) begin
                        r_dn    <= DIV_NW'({mul_p[DIV_NW-17:0], 16'b0});
                        r_dd    <= DIV_DW'(s2f_reg) + DIV_DW'(r_root);
                        r_ds    <= 1'b1;
                        r_state <= ST_D1;
                    end
                end
                ST_D1: begin
                    if (div_done) begin
                        r_y     <= y_min;
                        r_dn    <= DIV_NW'({r_pe, 30'b0});
                        r_dd    <= DIV_DW'(b_c);
                        r_ds    <= 1'b1;
                        r_state <= ST_D2;
                    end
                end
                // Split PE/b into integer and fraction
                ST_D2: begin
                    if (div_done) begin
                        r_boot <= 1'b0;
                        if (|div_q[DIV_NW-1:EXP_Q+5]) begin
                            r_ma    <= MUL_W'(r_y);
                            r_mb    <= '0;
                            r_ms    <= 1'b1;
                            r_state <= ST_S;
                        end else begin
                            r_n     <= div_q[EXP_Q+4:EXP_Q];
                            r_f     <= 31'(div_q[EXP_Q-1:0]);
                            r_sum   <= 34'(Q_ONE);
                            r_k     <= 5'd1;
                            r_ma    <= MUL_W'(Q_ONE);
                            r_mb    <= MUL_W'(div_q[EXP_Q-1:0]);
                            r_ms    <= 1'b1;
                            r_state <= ST_SER_M;
                        end
                    end
                end
                ST_SER_M: begin
                    if (mul_done) begin
                        r_dn    <= DIV_NW'(mul_p[MUL_PW-1:EXP_Q]);
                        r_dd    <= DIV_DW'(r_k);
                        r_ds    <= 1'b1;
                        r_state <= ST_SER_D;
                    end
                end
                // Accumulate one series term
                ST_SER_D: begin
                    if (div_done) begin
                        r_sum <= sum_next;
                        if (r_k == 5'(SER_TERMS)) begin
                            if (r_boot) begin
                                r_e1    <= e_clamp;
                                r_boot  <= 1'b0;
                                r_state <= ST_IDLE;
                            end else if (r_n == '0) begin
                                r_ma    <= MUL_W'(r_y);
                                r_mb    <= MUL_W'(e_clamp);
                                r_ms    <= 1'b1;
                                r_state <= ST_S;
                            end else begin
                                r_ma    <= MUL_W'(e_clamp);
                                r_mb    <= MUL_W'(r_e1);
                                r_ms    <= 1'b1;
                                r_state <= ST_POW;
                            end
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_ma    <= MUL_W'(div_q[30:0]);
                            r_mb    <= MUL_W'(r_f);
                            r_ms    <= 1'b1;
                            r_state <= ST_SER_M;
                        end
                    end
                end
                // Multiply by exp(-1) once per unit of the integer part
                ST_POW: begin
                    if (mul_done) begin
                        r_n  <= r_n - 1'b1;
                        r_ms <= 1'b1;
                        if (r_n == 5'd1) begin
                            r_ma    <= MUL_W'(r_y);
                            r_mb    <= MUL_W'(e_pow);
                            r_state <= ST_S;
                        end else begin
                            r_ma <= MUL_W'(e_pow);
                            r_mb <= MUL_W'(r_e1);
                        end
                    end
                end
                ST_S: begin
                    if (mul_done) begin
                        r_s     <= mul_p[EXP_Q+WATER_W-1:EXP_Q];
                        r_ma    <= MUL_W'(c_c);
                        r_mb    <= MUL_W'(diff_wy);
                        r_ms    <= 1'b1;
                        r_state <= ST_G1;
                    end
                end
                ST_G1: begin
                    if (mul_done) begin
                        r_dn    <= DIV_NW'({r_prev_ground, 16'b0}) + DIV_NW'(mul_p[37:0]);
                        r_dd    <= DIV_DW'(FRAC_ONE) + DIV_DW'(d_c);
                        r_ds    <= 1'b1;
                        r_state <= ST_G2;
                    end
                end
                ST_G2: begin
                    if (div_done) begin
                        r_g     <= g_sat;
                        r_ma    <= MUL_W'(FRAC_ONE - c_c);
                        r_mb    <= MUL_W'(diff_wy);
                        r_ms    <= 1'b1;
                        r_state <= ST_Q1;
                    end
                end
                ST_Q1: begin
                    if (mul_done) begin
                        r_t1    <= mul_p;
                        r_ma    <= MUL_W'(d_c);
                        r_mb    <= MUL_W'(r_g);
                        r_ms    <= 1'b1;
                        r_state <= ST_Q2;
                    end
                end
                ST_Q2: begin
                    if (mul_done) begin
                        r_qo    <= q_sat;
                        r_state <= ST_OUT;
                    end
                end
                // Hand the result to the output register and advance the state
                ST_OUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov                  <= 1'b1;
                        r_out.surface_runoff  <= r_qo;
                        r_out.groundwater     <= r_g;
                        r_out.available_water <= r_w;
                        r_out.et_opportunity  <= r_y;
                        r_out.soil_moisture   <= r_s;
                        r_out.actual_evap     <= r_y - r_s;
                        r_prev_soil           <= r_s;
                        r_prev_ground         <= r_g;
                        r_state               <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/awb_check.sv
module awb_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input awb_pkg::t_out_item            o_out_item,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready
);
    import awb_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // One item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // Evaporation and soil moisture split the opportunity
    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (21'(o_out_item.actual_evap) + 21'(o_out_item.soil_moisture))
                        == 21'(o_out_item.et_opportunity))
        else $error("evaporation split mismatch");

    // Opportunity never exceeds available water
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.et_opportunity <= o_out_item.available_water)
        else $error("opportunity above available water");

    // Register writes land only while idle with no arriving item
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> o_in_ready && !i_in_valid)
        else $error("register written while busy");

endmodule

bind abcd_water_balance_step_top awb_check u_awb_check (.*);

FILE: verif/tb_abcd_water_balance_step_top.sv
`default_nettype none

module tb_abcd_water_balance_step_top;
    timeunit 1ns;
    timeprecision 1ps;

    import awb_pkg::*;

    localparam longint unsigned WMAX       = (64'd1 << WATER_W) - 1;
    localparam longint unsigned ONE_F      = 64'd1 << FRAC_W;
    localparam longint unsigned CYCLE_CAP  = 64'd40_000_000;
    localparam int              PHASES     = 12;
    localparam int              PHASE_LEN  = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    abcd_water_balance_step_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the block's registers and carried state
    longint unsigned shadow_cfg [6];
    longint unsigned carry_soil;
    longint unsigned carry_ground;

    t_out_item       pending_months [$];
    int              error_count = 0;
    longint unsigned cycle_count = 0;
    int              ready_hold  = 0;
    bit              no_gaps;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        bit                   typed;
        t_in_item             month;
        t_out_item            want;
    } t_script_row;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned sat_w(longint unsigned v);
        return (v > WMAX) ? WMAX : v;
    endfunction

    function automatic logic [127:0] root_floor(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] trial;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            trial = res | (128'd1 << i);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    // exp(-f) for f in Q30, truncated series clamped at zero
    function automatic longint unsigned decay_frac(longint unsigned f);
        longint          sum;
        longint unsigned term;
        sum  = 64'sd1 << EXP_Q;
        term = 64'd1 << EXP_Q;
        for (int k = 1; k <= SER_TERMS; k++) begin
            term = ((term * f) >> EXP_Q) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    function automatic longint unsigned decay_ratio(longint unsigned pe, longint unsigned b);
        longint unsigned x;
        longint unsigned whole;
        longint unsigned e;
        longint unsigned e1;
        x     = (pe << EXP_Q) / b;
        whole = x >> EXP_Q;
        if (whole >= 32) return 64'd0;
        e  = decay_frac(x & ((64'd1 << EXP_Q) - 1));
        e1 = decay_frac(64'd1 << EXP_Q);
        for (longint unsigned i = 0; i < whole; i++) e = (e * e1) >> EXP_Q;
        return e;
    endfunction

    // Advance the water balance by one month and return its outputs
    function automatic t_out_item balance_month(t_in_item m);
        longint unsigned a, b, c, d, p, pe, w, y, s, g, q, rest, e;
        logic [127:0]    span, disc, root;
        t_out_item       o;
        a = shadow_cfg[CFG_RUNOFF_A];
        b = shadow_cfg[CFG_SAT_B];
        c = shadow_cfg[CFG_RECHARGE_C];
        d = shadow_cfg[CFG_DISCHARGE_D];
        if (a < 1) a = 1;
        if (a > ONE_F) a = ONE_F;
        if (b < 1) b = 1;
        if (c > ONE_F) c = ONE_F;
        if (d > ONE_F) d = ONE_F;
        p  = m.precipitation;
        pe = m.potential_evap;
        if (m.series_start) begin
            carry_soil   = sat_w(shadow_cfg[CFG_INIT_SOIL]);
            carry_ground = sat_w(shadow_cfg[CFG_INIT_GROUND]);
        end
        w    = sat_w(p + carry_soil);
        span = 128'(w + b) << FRAC_W;
        disc = span * span - ((128'(a) * 128'(w) * 128'(b)) << (FRAC_W + 2));
        root = root_floor(disc);
        y    = 64'(((128'(2 * w) * 128'(b)) << FRAC_W) / (span + root));
        if (y > w) y = w;
        e    = decay_ratio(pe, b);
        s    = (y * e) >> EXP_Q;
        rest = w - y;
        g    = sat_w(((carry_ground << FRAC_W) + c * rest) / (ONE_F + d));
        q    = sat_w(((ONE_F - c) * rest + d * g) >> FRAC_W);
        carry_soil   = s;
        carry_ground = g;
        o.surface_runoff  = q[WATER_W-1:0];
        o.groundwater     = g[WATER_W-1:0];
        o.available_water = w[WATER_W-1:0];
        o.et_opportunity  = y[WATER_W-1:0];
        o.soil_moisture   = s[WATER_W-1:0];
        o.actual_evap     = WATER_W'(y - s);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic check_month(t_out_item got, t_out_item want);
        if (got.surface_runoff != want.surface_runoff)
            report_mismatch("surface_runoff", got.surface_runoff, want.surface_runoff);
        if (got.groundwater != want.groundwater)
            report_mismatch("groundwater", got.groundwater, want.groundwater);
        if (got.available_water != want.available_water)
            report_mismatch("available_water", got.available_water, want.available_water);
        if (got.et_opportunity != want.et_opportunity)
            report_mismatch("et_opportunity", got.et_opportunity, want.et_opportunity);
        if (got.soil_moisture != want.soil_moisture)
            report_mismatch("soil_moisture", got.soil_moisture, want.soil_moisture);
        if (got.actual_evap != want.actual_evap)
            report_mismatch("actual_evap", got.actual_evap, want.actual_evap);
    endtask

    // Collect results and throttle the output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_hold  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_months.size() == 0) report_mismatch("unexpected item", 1, 0);
                else check_month(o_out_item, pending_months.pop_front());
            end
            if (ready_hold > 0) begin
                i_out_ready <= 1'b0;
                ready_hold  <= ready_hold - 1;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300)
                                                               : $urandom_range(1, 4);
            end
        end
    end

    // Drop the input valid, then idle for a random gap
    task automatic idle_gap();
        int n;
        if (no_gaps) return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
        if (n > 0) i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold a month on the input until it is taken, then predict it
    task automatic send_month(t_in_item m, bit typed, t_out_item want);
        t_out_item pred;
        i_cfg_valid <= 1'b0;
        i_in_valid  <= 1'b1;
        i_in_item   <= m;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pred = balance_month(m);
        pending_months.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_RUNOFF_A, CFG_RECHARGE_C, CFG_DISCHARGE_D:
                shadow_cfg[idx] = data & ((64'd1 << A_W) - 1);
            CFG_SAT_B:
                shadow_cfg[idx] = data & ((64'd1 << B_W) - 1);
            CFG_INIT_SOIL, CFG_INIT_GROUND:
                shadow_cfg[idx] = data;
            default: ;
        endcase
    endtask

    // Drop both valids, wait for every outstanding month, then let the block settle
    task automatic drain();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_months.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_reg(t_cfg_idx idx);
        int r;
        r = $urandom_range(0, 9);
        case (idx)
            CFG_RUNOFF_A:
                return (r == 0) ? 20'd1 : (r == 1) ? 20'd65536 : (r == 2) ? 20'h1FFFF
                     : CFG_DAT_W'($urandom_range(1, 65536));
            CFG_SAT_B:
                return (r == 0) ? 20'd100 : (r == 1) ? 20'd500000 : (r == 2) ? 20'h7FFFF
                     : CFG_DAT_W'($urandom_range(100, 500000));
            CFG_RECHARGE_C, CFG_DISCHARGE_D:
                return (r == 0) ? 20'd0 : (r == 1) ? 20'd65536 : (r == 2) ? 20'h1FFFF
                     : CFG_DAT_W'($urandom_range(0, 65536));
            default:
                return (r == 0) ? 20'hFFFFF
                     : (r < 3) ? CFG_DAT_W'($urandom_range(0, 1048575))
                     : CFG_DAT_W'($urandom_range(0, 60000));
        endcase
    endfunction

    function automatic logic [WATER_W-1:0] pick_water();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return WATER_W'($urandom_range(0, 40000));
        if (r < 8) return WATER_W'($urandom_range(0, 300000));
        return WATER_W'($urandom());
    endfunction

    t_script_row script [$];

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        t_script_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        script.push_back(row);
    endfunction

    function automatic void add_month(logic [WATER_W-1:0] p, logic [WATER_W-1:0] pe, bit st,
                                      bit typed = 1'b0);
        t_script_row row;
        row       = '{default: '0};
        row.month = '{precipitation: p, potential_evap: pe, series_start: st};
        row.typed = typed;
        script.push_back(row);
    endfunction

    initial begin
        t_in_item  m;
        t_out_item none;
        none         = '0;
        no_gaps      = 1'b0;
        carry_soil   = 0;
        carry_ground = 0;
        shadow_cfg[CFG_RUNOFF_A]    = RST_A;
        shadow_cfg[CFG_SAT_B]       = RST_B;
        shadow_cfg[CFG_RECHARGE_C]  = RST_C;
        shadow_cfg[CFG_DISCHARGE_D] = RST_D;
        shadow_cfg[CFG_INIT_SOIL]   = 0;
        shadow_cfg[CFG_INIT_GROUND] = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: dry months from reset, field extremes, overflow, series restart
        add_month(20'd0, 20'd0, 1'b0, 1'b1);
        add_month(20'd0, 20'd0, 1'b1, 1'b1);
        add_month(20'hFFFFF, 20'd0, 1'b0);
        add_month(20'hFFFFF, 20'hFFFFF, 1'b0);
        add_month(20'd0, 20'hFFFFF, 1'b0);
        add_month(20'd12000, 20'd8000, 1'b0);
        // Out-of-range fractions, zero saturation, full initial stores
        add_cfg(CFG_RUNOFF_A, 20'd0);
        add_cfg(CFG_SAT_B, 20'd0);
        add_cfg(CFG_RECHARGE_C, 20'h1FFFF);
        add_cfg(CFG_DISCHARGE_D, 20'h1FFFF);
        add_cfg(CFG_INIT_SOIL, 20'hFFFFF);
        add_cfg(CFG_INIT_GROUND, 20'hFFFFF);
        add_cfg(CFG_UNUSED, 20'hABCDE);
        add_cfg(CFG_TOP, 20'h12345);
        add_month(20'hFFFFF, 20'd1, 1'b1);
        add_month(20'd5000, 20'd3, 1'b0);
        add_month(20'd0, 20'd0, 1'b1);
        // Oversized a, widest b
        add_cfg(CFG_RUNOFF_A, 20'h1FFFF);
        add_cfg(CFG_SAT_B, 20'h7FFFF);
        add_month(20'hFFFFF, 20'hFFFFF, 1'b1);
        add_month(20'd30000, 20'd20000, 1'b0);
        // Lowest legal settings
        add_cfg(CFG_RUNOFF_A, 20'd1);
        add_cfg(CFG_SAT_B, 20'd100);
        add_cfg(CFG_RECHARGE_C, 20'd0);
        add_cfg(CFG_DISCHARGE_D, 20'd0);
        add_cfg(CFG_INIT_SOIL, 20'd0);
        add_cfg(CFG_INIT_GROUND, 20'd50000);
        add_month(20'd10000, 20'd50, 1'b1);
        add_month(20'd400, 20'd3199, 1'b0);
        add_month(20'hAAAAA, 20'h55555, 1'b0);
        add_month(20'h55555, 20'hAAAAA, 1'b0);
        // Highest legal settings
        add_cfg(CFG_RUNOFF_A, 20'd65536);
        add_cfg(CFG_SAT_B, 20'd500000);
        add_cfg(CFG_RECHARGE_C, 20'd65536);
        add_cfg(CFG_DISCHARGE_D, 20'd65536);
        add_month(20'd80000, 20'd70000, 1'b1);
        add_month(20'd0, 20'd100, 1'b0);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_month(script[i].month, script[i].typed, none);
                idle_gap();
            end
        end

        // Random phases, each with fresh settings and a series start
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            for (int r = 0; r < 6; r++) write_reg(CFG_IDX_W'(r), pick_reg(t_cfg_idx'(r)));
            no_gaps = (ph % 3 == 2);
            for (int k = 0; k < PHASE_LEN; k++) begin
                m.precipitation  = pick_water();
                m.potential_evap = pick_water();
                m.series_start   = (k == 0) || ($urandom_range(0, 24) == 0);
                send_month(m, 1'b0, none);
                idle_gap();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_months.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
